[design/zpsf_pkg.sv]
// shared types, constants and helpers of the zero-phase smoothing filter
// no dependencies; imported by every module of the block

package zpsf_pkg;

  localparam int unsigned DEPTH_DEFAULT = 1024;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEVEL_W  = 15;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned PASS_W   = 8;
  localparam int unsigned SUM_W    = 18;
  localparam int unsigned DIV_W    = 3;
  localparam int unsigned RECIP_W  = 19;
  localparam int unsigned RECIP_SH = 20;
  localparam int unsigned PROD_W   = SUM_W + RECIP_W;
  localparam int unsigned QUOT_W   = PROD_W - RECIP_SH;
  localparam int unsigned REM_W    = QUOT_W + DIV_W;

  localparam logic [PASS_W-1:0]  PASS_RESET = 8'd1;
  localparam logic [LEVEL_W-1:0] MIN_RESET  = 15'h7FFF;
  localparam logic [LEVEL_W-1:0] MAX_RESET  = 15'h0000;

  // divisors: weight sum actually used
  localparam logic [DIV_W-1:0] DIV3 = 3'd3;
  localparam logic [DIV_W-1:0] DIV5 = 3'd5;
  localparam logic [DIV_W-1:0] DIV6 = 3'd6;

  // floor(2^RECIP_SH / d)
  localparam logic [RECIP_W-1:0] RECIP3 = 19'd349525;
  localparam logic [RECIP_W-1:0] RECIP5 = 19'd209715;
  localparam logic [RECIP_W-1:0] RECIP6 = 19'd174762;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SMOOTH = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } zpsf_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BWD_INIT,
    ST_BWD_RUN,
    ST_BWD_DRAIN,
    ST_FWD_INIT,
    ST_FWD_RUN,
    ST_FWD_DRAIN,
    ST_DONE
  } zpsf_state_e;

  typedef struct packed {
    zpsf_op_e                    operation;
    logic signed [SAMPLE_W-1:0]  sample_in;
  } zpsf_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  sample_out;
    logic                        is_last;
    logic [LEVEL_W-1:0]          max_level;
    logic [LEVEL_W-1:0]          min_level;
    logic [COUNT_W-1:0]          sample_count;
    logic                        overflow;
  } zpsf_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic read;
    logic smooth;
    logic respond;
    logic pass_init;
    logic pass_fwd;
    logic issue;
  } zpsf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic idx_last;
    logic pipe_busy;
  } zpsf_sts_t;

  function automatic logic [RECIP_W-1:0] recip(input logic [DIV_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      DIV5:    r = RECIP5;
      DIV6:    r = RECIP6;
      default: r = RECIP3;
    endcase
    return r;
  endfunction

endpackage

[design/zpsf_ctrl.sv]
// controller of the smoothing filter: command decode, pass sequencing, config register
// depends on zpsf_pkg

module zpsf_ctrl import zpsf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  zpsf_op_e            op_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [PASS_W-1:0]   cfg_data_i,
  input  zpsf_sts_t           sts_i,
  output zpsf_cmd_t           cmd_o
);

  zpsf_state_e         state_q, state_d;
  logic [PASS_W-1:0]   pass_cnt_q;
  logic [PASS_W-1:0]   round_q;
  logic                smooth_acc;

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign smooth_acc  = (state_q == ST_IDLE) && start && (op_i == OP_SMOOTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pass_cnt_q <= PASS_RESET;
      round_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        pass_cnt_q <= cfg_data_i;
      end
      if (smooth_acc) begin
        round_q <= pass_cnt_q;
      end else if (state_q == ST_FWD_DRAIN && !sts_i.pipe_busy) begin
        round_q <= round_q - PASS_W'(1);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (smooth_acc) begin
          state_d = (pass_cnt_q == '0) ? ST_DONE : ST_BWD_INIT;
        end
      end
      ST_BWD_INIT:  state_d = sts_i.empty ? ST_BWD_DRAIN : ST_BWD_RUN;
      ST_BWD_RUN:   if (sts_i.idx_last) state_d = ST_BWD_DRAIN;
      ST_BWD_DRAIN: if (!sts_i.pipe_busy) state_d = ST_FWD_INIT;
      ST_FWD_INIT:  state_d = sts_i.empty ? ST_FWD_DRAIN : ST_FWD_RUN;
      ST_FWD_RUN:   if (sts_i.idx_last) state_d = ST_FWD_DRAIN;
      ST_FWD_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = (round_q == PASS_W'(1)) ? ST_DONE : ST_BWD_INIT;
        end
      end
      ST_DONE:      state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load    = start && (op_i == OP_LOAD);
        cmd_o.read    = start && (op_i == OP_READ);
        cmd_o.smooth  = smooth_acc;
        cmd_o.respond = start && (op_i == OP_LOAD || op_i == OP_READ);
      end
      ST_BWD_INIT: cmd_o.pass_init = 1'b1;
      ST_BWD_RUN:  cmd_o.issue = 1'b1;
      ST_FWD_INIT: begin
        cmd_o.pass_init = 1'b1;
        cmd_o.pass_fwd  = 1'b1;
      end
      ST_FWD_RUN: begin
        cmd_o.issue    = 1'b1;
        cmd_o.pass_fwd = 1'b1;
      end
      ST_DONE:     cmd_o.respond = 1'b1;
      default:     cmd_o = '0;
    endcase
  end

endmodule

[design/zpsf_dpath.sv]
// datapath of the smoothing filter: sample store, scratch store, weighted-average pipeline,
// trackers and result register; depends on zpsf_pkg

module zpsf_dpath import zpsf_pkg::*; #(
  parameter  int unsigned DEPTH = DEPTH_DEFAULT,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  zpsf_cmd_t                   cmd_i,
  input  logic signed [SAMPLE_W-1:0]  sample_i,
  output zpsf_sts_t                   sts_o,
  output logic                        res_valid_o,
  output zpsf_out_t                   res_o
);

  logic signed [SAMPLE_W-1:0] store_mem [DEPTH];
  logic signed [SAMPLE_W-1:0] scr_mem   [DEPTH];
  logic signed [SAMPLE_W-1:0] store_rd_q, scr_rd_q;

  logic [CW-1:0]      load_cnt_q, rd_ptr_q;
  logic [LEVEL_W-1:0] max_q, min_q;
  logic               ovf_q, res_valid_q, rd_ok_q, last_q;
  logic               dir_q;
  logic [AW-1:0]      idx_q;
  logic [1:0]         iss_cnt_q;

  // stage 1: memory data back
  logic               v1_q, e1_q, e2_q;
  logic [AW-1:0]      idx1_q;
  logic signed [SAMPLE_W-1:0] w1_q, w2_q;
  // stage 2: sum and divisor
  logic               v2_q, neg2_q;
  logic [SUM_W-1:0]   x2_q;
  logic [DIV_W-1:0]   div2_q;
  logic signed [SAMPLE_W-1:0] ctr2_q;
  logic [AW-1:0]      idx2_q;
  // stage 3: reciprocal product
  logic               v3_q, neg3_q;
  logic [PROD_W-1:0]  prod3_q;
  logic [SUM_W-1:0]   x3_q;
  logic [DIV_W-1:0]   div3_q;
  logic signed [SAMPLE_W-1:0] ctr3_q;
  logic [AW-1:0]      idx3_q;

  logic               load_ok, rd_ok, rd_last;
  logic [AW-1:0]      last_idx, store_raddr, store_waddr;
  logic               store_we, scr_we;
  logic signed [SAMPLE_W-1:0] store_wdata;

  logic signed [SAMPLE_W-1:0] cur;
  logic               t1, t2;
  logic [SUM_W-1:0]   c18, sum1, x1;
  logic [DIV_W-1:0]   div1;

  logic [QUOT_W-1:0]  q0, q;
  logic [REM_W-1:0]   qd, rem;
  logic signed [SAMPLE_W-1:0] res3;

  assign load_ok  = cmd_i.load && (load_cnt_q < CW'(DEPTH));
  assign rd_ok    = cmd_i.read && (rd_ptr_q < load_cnt_q);
  assign rd_last  = ((rd_ptr_q + CW'(1)) == load_cnt_q);
  assign last_idx = AW'(load_cnt_q - CW'(1));

  assign sts_o.empty     = (load_cnt_q == '0);
  assign sts_o.idx_last  = dir_q ? (idx_q == '0) : (idx_q == last_idx);
  assign sts_o.pipe_busy = v1_q || v2_q || v3_q;

  // stage 1 weighting: 3*center + 2*near + far, far only when near counts
  assign cur  = dir_q ? scr_rd_q : store_rd_q;
  assign t1   = e1_q && !w1_q[SAMPLE_W-1];
  assign t2   = t1 && e2_q && !w2_q[SAMPLE_W-1];
  assign c18  = SUM_W'(cur[SAMPLE_W-2:0]);
  always_comb begin
    sum1 = c18 + (c18 << 1);
    div1 = DIV3;
    if (t1) begin
      sum1 = sum1 + (SUM_W'(w1_q[SAMPLE_W-2:0]) << 1);
      div1 = DIV5;
    end
    if (t2) begin
      sum1 = sum1 + SUM_W'(w2_q[SAMPLE_W-2:0]);
      div1 = DIV6;
    end
    x1 = sum1 + SUM_W'(div1 >> 1);
  end

  // stage 3: quotient estimate is exact or one low
  assign q0   = prod3_q[PROD_W-1:RECIP_SH];
  assign qd   = REM_W'(q0) * REM_W'(div3_q);
  assign rem  = REM_W'(x3_q) - qd;
  assign q    = (rem >= REM_W'(div3_q)) ? (q0 + QUOT_W'(1)) : q0;
  assign res3 = neg3_q ? ctr3_q : $signed({1'b0, q[LEVEL_W-1:0]});

  // memory ports
  assign store_raddr = cmd_i.read ? rd_ptr_q[AW-1:0] : idx_q;
  assign store_we    = load_ok || (v3_q && dir_q);
  assign store_waddr = load_ok ? load_cnt_q[AW-1:0] : idx3_q;
  assign store_wdata = load_ok ? sample_i : res3;
  assign scr_we      = v3_q && !dir_q;

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[store_waddr] <= store_wdata;
    end
    store_rd_q <= store_mem[store_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (scr_we) begin
      scr_mem[idx3_q] <= res3;
    end
    scr_rd_q <= scr_mem[idx_q];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q  <= '0;
      rd_ptr_q    <= '0;
      max_q       <= MAX_RESET;
      min_q       <= MIN_RESET;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
      rd_ok_q     <= 1'b0;
      last_q      <= 1'b0;
      dir_q       <= 1'b0;
      idx_q       <= '0;
      iss_cnt_q   <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.respond;
      rd_ok_q     <= rd_ok;
      last_q      <= rd_ok && rd_last;
      v1_q        <= cmd_i.issue;
      v2_q        <= v1_q;
      v3_q        <= v2_q;

      if (load_ok) begin
        load_cnt_q <= load_cnt_q + CW'(1);
      end else if (cmd_i.load) begin
        ovf_q <= 1'b1;
      end

      if (cmd_i.smooth) begin
        rd_ptr_q <= '0;
      end else if (rd_ok) begin
        rd_ptr_q <= rd_ptr_q + CW'(1);
      end

      if (cmd_i.pass_init) begin
        dir_q     <= cmd_i.pass_fwd;
        idx_q     <= cmd_i.pass_fwd ? last_idx : '0;
        iss_cnt_q <= '0;
      end else if (cmd_i.issue) begin
        idx_q <= dir_q ? (idx_q - AW'(1)) : (idx_q + AW'(1));
        if (iss_cnt_q != 2'd2) begin
          iss_cnt_q <= iss_cnt_q + 2'd1;
        end
      end

      if (cmd_i.pass_init && cmd_i.pass_fwd) begin
        max_q <= MAX_RESET;
        min_q <= MIN_RESET;
      end else if (v3_q && dir_q && !res3[SAMPLE_W-1]) begin
        if (res3[LEVEL_W-1:0] > max_q) max_q <= res3[LEVEL_W-1:0];
        if (res3[LEVEL_W-1:0] < min_q) min_q <= res3[LEVEL_W-1:0];
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      e1_q   <= (iss_cnt_q != 2'd0);
      e2_q   <= (iss_cnt_q == 2'd2);
      idx1_q <= idx_q;
    end
    if (v1_q) begin
      w1_q   <= cur;
      w2_q   <= w1_q;
      x2_q   <= x1;
      div2_q <= div1;
      neg2_q <= cur[SAMPLE_W-1];
      ctr2_q <= cur;
      idx2_q <= idx1_q;
    end
    if (v2_q) begin
      prod3_q <= PROD_W'(x2_q) * PROD_W'(recip(div2_q));
      x3_q    <= x2_q;
      div3_q  <= div2_q;
      neg3_q  <= neg2_q;
      ctr3_q  <= ctr2_q;
      idx3_q  <= idx2_q;
    end
  end

  assign res_valid_o        = res_valid_q;
  assign res_o.sample_out   = rd_ok_q ? store_rd_q : '0;
  assign res_o.is_last      = last_q;
  assign res_o.max_level    = max_q;
  assign res_o.min_level    = min_q;
  assign res_o.sample_count = COUNT_W'(load_cnt_q);
  assign res_o.overflow     = ovf_q;

endmodule

[design/zero_phase_smoothing_filter_unit.sv]
// top level of the zero-phase 3-2-1 smoothing filter
// depends on zpsf_pkg, zpsf_ctrl and zpsf_dpath
//
// usage:
//   command channel: cmd_i (operation, sample_in) is taken at a rising edge with
//     start high and busy low. load appends a sample, smooth runs pass_count
//     rounds of backward then forward 3-2-1 averaging, read returns the next
//     stored sample, operation 3 is a no-op with no result.
//   result channel: res_valid_o marks res_o for exactly one cycle; the receiver
//     cannot stall, so every result must be taken in that cycle.
//   config channel: cfg_data_i is written into pass_count when cfg_valid_i and
//     cfg_ready_o are both high; ready is high while the block is idle.
//   latency and throughput:
//     load and read: busy stays low, one transaction per cycle, result in the
//       cycle after the transaction.
//     smooth: busy until the last round is done; each pass streams one sample
//       a cycle through the read port of the store or of the scratch store
//       and a three-stage weighting pipeline that must drain between passes.
//       the result comes in the first cycle with busy low.
//   reset: store empty, pass_count 1, trackers 0 and 32767, overflow clear.
//     store contents are not cleared; only loaded entries are ever read.

module zero_phase_smoothing_filter_unit import zpsf_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  zpsf_in_t           cmd_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [PASS_W-1:0]  cfg_data_i,
  output logic               res_valid_o,
  output zpsf_out_t          res_o
);

  // command and status between controller and datapath
  zpsf_cmd_t cmd;
  zpsf_sts_t sts;

  // controller: decodes commands, sequences rounds and passes
  zpsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .op_i        (cmd_i.operation),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: stores, weighting pipeline, trackers, result register
  zpsf_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sample_i    (cmd_i.sample_in),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

[design/zpsf_checker.sv]
// port-level checks of the smoothing filter, bound to the top level
// depends on zpsf_pkg and zero_phase_smoothing_filter_unit

module zpsf_checker import zpsf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  zpsf_in_t           cmd_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [PASS_W-1:0]  cfg_data_i,
  input  logic               res_valid_o,
  input  zpsf_out_t          res_o
);

  // load or read gives a result in the next cycle
  a_stream_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i.operation == OP_LOAD || cmd_i.operation == OP_READ)
    |=> res_valid_o)
    else $error("load or read without result");

  // no-op gives no result
  a_nop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i.operation == OP_NOP |=> !res_valid_o)
    else $error("result after no-op");

  // smooth always occupies the block
  a_smooth_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i.operation == OP_SMOOTH |=> busy && !res_valid_o)
    else $error("smooth did not raise busy");

  // last sample only with a non-empty store
  a_last_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.is_last |-> res_o.sample_count != '0)
    else $error("last flag on empty store");

endmodule

bind zero_phase_smoothing_filter_unit zpsf_checker u_zpsf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .cmd_i       (cmd_i),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_data_i  (cfg_data_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

[test/zpsf_smooth_checker.sv]
`timescale 1ns / 1ps
// result checker for the zero-phase smoothing filter: predicts every result
// from the accepted command and config transactions and compares; uses zpsf_pkg

module zpsf_smooth_checker import zpsf_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  zpsf_in_t           cmd_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [PASS_W-1:0]  cfg_data_i,
  input  logic               res_valid_i,
  input  zpsf_out_t          res_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);

  localparam int unsigned MAX_REPORTS = 10;

  logic signed [SAMPLE_W-1:0] model_store [DEPTH];
  logic signed [SAMPLE_W-1:0] pass_buf    [DEPTH];
  int unsigned                model_count;
  int unsigned                model_rd_ptr;
  logic [LEVEL_W-1:0]         model_max;
  logic [LEVEL_W-1:0]         model_min;
  logic                       model_ovf;
  logic [PASS_W-1:0]          model_passes;

  zpsf_out_t   expected_results [$];
  int unsigned fails   = 0;
  int unsigned pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  // 3-2-1 weighted mean; a term counts only if it exists, is valid and its
  // nearer neighbour counted too; rounding half up
  function automatic logic signed [SAMPLE_W-1:0] weigh_321(
    input logic signed [SAMPLE_W-1:0] here,
    input logic signed [SAMPLE_W-1:0] near,
    input logic signed [SAMPLE_W-1:0] far,
    input bit has_near,
    input bit has_far
  );
    int unsigned wsum;
    int unsigned wdiv;
    if (here < 0) return here;
    wsum = 3 * here;
    wdiv = 3;
    if (has_near && near >= 0) begin
      wsum += 2 * near;
      wdiv += 2;
      if (has_far && far >= 0) begin
        wsum += far;
        wdiv += 1;
      end
    end
    return SAMPLE_W'((wsum + wdiv / 2) / wdiv);
  endfunction

  function automatic void run_smoothing();
    int n;
    int i;
    logic signed [SAMPLE_W-1:0] s;
    n = model_count;
    for (int r = 0; r < int'(model_passes); r++) begin
      // backward pass reads only the values from before the pass
      for (i = 0; i < n; i++) begin
        pass_buf[i] = weigh_321(model_store[i],
                                (i >= 1) ? model_store[i-1] : '0,
                                (i >= 2) ? model_store[i-2] : '0,
                                i >= 1, i >= 2);
      end
      model_max = MAX_RESET;
      model_min = MIN_RESET;
      for (i = 0; i < n; i++) begin
        s = weigh_321(pass_buf[i],
                      (i + 1 < n) ? pass_buf[i+1] : '0,
                      (i + 2 < n) ? pass_buf[i+2] : '0,
                      i + 1 < n, i + 2 < n);
        model_store[i] = s;
        if (s >= 0) begin
          if (LEVEL_W'(s) > model_max) model_max = LEVEL_W'(s);
          if (LEVEL_W'(s) < model_min) model_min = LEVEL_W'(s);
        end
      end
    end
  endfunction

  function automatic zpsf_out_t predict_result(input zpsf_in_t cmd);
    zpsf_out_t r;
    r = '0;
    case (cmd.operation)
      OP_LOAD: begin
        if (model_count < DEPTH) begin
          model_store[model_count] = cmd.sample_in;
          model_count++;
        end else begin
          model_ovf = 1'b1;
        end
      end
      OP_SMOOTH: begin
        run_smoothing();
        model_rd_ptr = 0;
      end
      default: begin
        if (model_rd_ptr < model_count) begin
          r.sample_out = model_store[model_rd_ptr];
          r.is_last    = (model_rd_ptr + 1 == model_count);
          model_rd_ptr++;
        end
      end
    endcase
    r.max_level    = model_max;
    r.min_level    = model_min;
    r.sample_count = COUNT_W'(model_count);
    r.overflow     = model_ovf;
    return r;
  endfunction

  function automatic string fmt_result(input zpsf_out_t r);
    return $sformatf("sample=%0d last=%b max=%0d min=%0d count=%0d ovf=%b",
                     r.sample_out, r.is_last, r.max_level, r.min_level,
                     r.sample_count, r.overflow);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    zpsf_out_t want;
    if (!rst_ni) begin
      model_count  = 0;
      model_rd_ptr = 0;
      model_max    = MAX_RESET;
      model_min    = MIN_RESET;
      model_ovf    = 1'b0;
      model_passes = PASS_RESET;
      expected_results.delete();
      pending      = 0;
    end else begin
      // a result always belongs to an earlier command, so check it first
      if (res_valid_i) begin
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("unexpected result: %s", fmt_result(res_i));
        end else begin
          want = expected_results.pop_front();
          if (res_i !== want) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display("result mismatch: expected %s, got %s",
                       fmt_result(want), fmt_result(res_i));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) model_passes = cfg_data_i;
      if (start_i && !busy_i && cmd_i.operation != OP_NOP)
        expected_results.push_back(predict_result(cmd_i));
      pending = expected_results.size();
    end
  end

endmodule

[test/tb_zero_phase_smoothing_filter_unit.sv]
`timescale 1ns / 1ps
// testbench top for zero_phase_smoothing_filter_unit: drives command and
// config transactions, gives the verdict; depends on zpsf_pkg and zpsf_smooth_checker

module tb_zero_phase_smoothing_filter_unit import zpsf_pkg::*;;

  localparam int unsigned ITEMS        = 1900;
  localparam int unsigned IDLE_GUARD   = 4;
  localparam int unsigned DRAIN_CYCLES = 32;
  // worst case is full-store smoothing rounds plus gaps; the limit
  // leaves a wide margin above that
  localparam int unsigned LIMIT        = 5_000_000;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start_q     = 1'b0;
  zpsf_in_t          cmd_q       = '0;
  logic              cfg_valid_q = 1'b0;
  logic [PASS_W-1:0] cfg_data_q  = '0;
  logic              busy;
  logic              cfg_ready_o;
  logic              res_valid_o;
  zpsf_out_t         res_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned loads_issued  = 0;
  int unsigned burst_left    = 0;

  zero_phase_smoothing_filter_unit #(
    .DEPTH(DEPTH_DEFAULT)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start_q),
    .busy       (busy),
    .cmd_i      (cmd_q),
    .cfg_valid_i(cfg_valid_q),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_q),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  zpsf_smooth_checker #(
    .DEPTH(DEPTH_DEFAULT)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_q),
    .busy_i      (busy),
    .cmd_i       (cmd_q),
    .cfg_valid_i (cfg_valid_q),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_q),
    .res_valid_i (res_valid_o),
    .res_i       (res_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("tb_zero_phase_smoothing_filter_unit failed");
      $finish;
    end
  end

  // mostly valid samples, with invalid markers and the range ends mixed in
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] r;
    r = SAMPLE_W'($urandom);
    case ($urandom_range(0, 9))
      0:       r = 16'h7FFF;
      1:       r = 16'h0000;
      2, 3:    r[SAMPLE_W-1] = 1'b1;
      4:       r = SAMPLE_W'($urandom_range(0, 15));
      default: r[SAMPLE_W-1] = 1'b0;
    endcase
    return r;
  endfunction

  // high pass counts only while the store is small, to bound smoothing time
  function automatic logic [PASS_W-1:0] choose_passes(input int unsigned held);
    if (held <= 16) begin
      case ($urandom_range(0, 4))
        0:       return '0;
        1:       return '1;
        2:       return PASS_W'($urandom_range(0, 255));
        default: return PASS_W'($urandom_range(1, 3));
      endcase
    end
    if (held <= 200) return PASS_W'($urandom_range(0, 6));
    return PASS_W'($urandom_range(0, 2));
  endfunction

  // burst pacing: random burst length, random gap before each burst
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        start_q <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // one command transaction; returns at the edge that accepts it
  task automatic send(input zpsf_op_e op, input logic signed [SAMPLE_W-1:0] val);
    pace();
    cmd_q   <= '{operation: op, sample_in: val};
    start_q <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (op != OP_NOP) items_sent++;
    if (op == OP_LOAD) loads_issued++;
  endtask

  // hold off until every expected result is in, then wait out the idle guard for a no-op
  task automatic wait_idle();
    start_q <= 1'b0;
    @(negedge clk_i);
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (IDLE_GUARD) @(posedge clk_i);
  endtask

  task automatic write_passes(input logic [PASS_W-1:0] value);
    wait_idle();
    cfg_valid_q <= 1'b1;
    cfg_data_q  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_q <= 1'b0;
  endtask

  // occasional stray command: breaks up the load/smooth/read sequences
  task automatic sprinkle_noise();
    if ($urandom_range(0, 11) == 0)
      send(zpsf_op_e'($urandom_range(0, 3)), pick_sample());
  endtask

  function automatic int unsigned held_samples();
    return (loads_issued < DEPTH_DEFAULT) ? loads_issued : DEPTH_DEFAULT;
  endfunction

  // well-formed round: set pass count, load, smooth, read back
  task automatic run_round();
    int unsigned n_loads;
    int unsigned n_reads;
    int unsigned held;
    write_passes(choose_passes(held_samples()));
    n_loads = $urandom_range(0, 30);
    repeat (n_loads) begin
      sprinkle_noise();
      send(OP_LOAD, pick_sample());
    end
    send(OP_SMOOTH, pick_sample());
    held = held_samples();
    n_reads = $urandom_range(0, (held <= 64) ? held + 2 : 16);
    repeat (n_reads) begin
      sprinkle_noise();
      send(OP_READ, pick_sample());
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store: smooth resets trackers, read past the end
    send(OP_SMOOTH, 16'sh0000);
    send(OP_READ, 16'shFFFF);

    // range ends and invalid markers next to valid data
    send(OP_LOAD, 16'sh7FFF);
    send(OP_LOAD, 16'sh8000);
    send(OP_LOAD, 16'sh0000);
    send(OP_LOAD, 16'shFFFF);
    send(OP_LOAD, 16'sh0001);
    send(OP_LOAD, 16'sh0002);
    send(OP_LOAD, 16'sh7FFF);
    send(OP_LOAD, 16'sh7FFE);
    send(OP_SMOOTH, 16'sh0000);
    // read every sample, the last flagged, then one past the end
    repeat (9) send(OP_READ, 16'sh0000);
    send(OP_NOP, pick_sample());

    // zero passes leave samples and trackers alone
    write_passes('0);
    send(OP_SMOOTH, 16'sh0000);
    repeat (2) send(OP_READ, 16'sh0000);

    // largest pass count on a small store
    write_passes('1);
    send(OP_SMOOTH, 16'sh0000);
    repeat (2) send(OP_READ, 16'sh0000);

    // random rounds; the store fills up along the way
    while (items_sent < ITEMS) run_round();

    // make sure loads beyond capacity are seen to be dropped
    while (loads_issued < DEPTH_DEFAULT + 3) send(OP_LOAD, pick_sample());
    write_passes(PASS_W'(1));
    send(OP_SMOOTH, 16'sh0000);
    repeat (8) send(OP_READ, pick_sample());

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_zero_phase_smoothing_filter_unit passed");
    end else begin
      $display("tb_zero_phase_smoothing_filter_unit failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/zpsf_pkg.sv
design/zpsf_ctrl.sv
design/zpsf_dpath.sv
design/zero_phase_smoothing_filter_unit.sv
design/zpsf_checker.sv
test/zpsf_smooth_checker.sv
test/tb_zero_phase_smoothing_filter_unit.sv
